// File: design/csh_pkg.sv
// Shared constants and state codes for the Collatz section hash block.
package csh_pkg;

  // Width of one message byte and of the emitted section index field
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_IDX_W = 5;
  localparam int unsigned LIMIT_W   = 32;

  // Sequencer state vector
  typedef logic [2:0] state_t;

  localparam state_t S_IDLE  = 3'd0;  // waiting for a byte
  localparam state_t S_ADD   = 3'd1;  // read-modify-write of one section sum
  localparam state_t S_DSIZE = 3'd2;  // short message: find doubled length
  localparam state_t S_DRD   = 3'd3;  // short message: read prefix and sum
  localparam state_t S_DWR   = 3'd4;  // short message: write updated sum
  localparam state_t S_CRD   = 3'd5;  // hash: read section sum
  localparam state_t S_CLD   = 3'd6;  // hash: load value into step unit
  localparam state_t S_CRUN  = 3'd7;  // hash: one Collatz step per cycle

endpackage

// File: design/collatz_section_hash_core.sv
// Collatz section hash: byte accumulation, short-message fill and hash sequencer.
//
// Each message byte is one read-modify-write of the section sum memory
// (S_IDLE, S_ADD). On the last byte of a message shorter than SECTIONS bytes,
// the prefix is replayed: S_DSIZE doubles the length until it covers all
// sections, then S_DRD/S_DWR add each replayed byte. The hash phase then walks
// the sections in order (S_CRD, S_CLD, then S_CRUN steps each section sum);
// the step count is bounded by step_limit, and a stalled output holds the
// sequencer once the next result is ready. A step unit apart from the sum
// adder does the Collatz steps. Sums are cleared through per-section valid
// bits, so no clearing pass is needed after reset or between messages. in_stall
// is high from the transfer of a byte until the block is ready for the next one.
module collatz_section_hash_core #(
  parameter int unsigned SECTIONS  = 32,
  parameter int unsigned SUM_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [csh_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             in_last_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [csh_pkg::BYTE_W-1:0]       out_hash_byte,
  output logic [csh_pkg::OUT_IDX_W-1:0]    out_section_index,
  output logic                             out_timed_out,
  output logic                             out_last_result,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csh_pkg::LIMIT_W-1:0]      cfg_step_limit
);

  localparam int unsigned IDX_W = $clog2(SECTIONS);
  localparam int unsigned J_W   = IDX_W + 1;
  localparam int unsigned BW    = csh_pkg::BYTE_W;

  localparam int unsigned OUT_IDX_PAD = csh_pkg::OUT_IDX_W;

  localparam logic [IDX_W-1:0] LAST_SEC = IDX_W'(SECTIONS - 1);
  localparam logic [J_W-1:0]   SEC_J    = J_W'(SECTIONS);

  // Control state
  csh_pkg::state_t           state_r, state_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;
  logic                      long_r, long_nxt;
  logic [SECTIONS-1:0]       valid_r, valid_nxt;
  logic [csh_pkg::LIMIT_W-1:0] limit_r;

  // Latched input transfer
  logic [BW-1:0]             byte_r, byte_nxt;
  logic                      last_r, last_nxt;

  // Short-message fill counters
  logic [IDX_W-1:0]          len_r, len_nxt;
  logic [IDX_W-1:0]          src_r, src_nxt;
  logic [IDX_W-1:0]          dst_r, dst_nxt;
  logic [J_W-1:0]            j_r, j_nxt;
  logic [J_W-1:0]            total_r, total_nxt;

  // Collatz step unit
  logic [IDX_W-1:0]          sec_r, sec_nxt;
  logic [SUM_WIDTH-1:0]      v_r, v_nxt;
  logic [BW-1:0]             hash_r, hash_nxt;
  logic [csh_pkg::LIMIT_W-1:0] steps_r, steps_nxt;

  // Output register
  logic                      ovalid_r, ovalid_nxt;
  logic [BW-1:0]             ohash_r, ohash_nxt;
  logic [IDX_W-1:0]          oidx_r, oidx_nxt;
  logic                      oto_r, oto_nxt;
  logic                      olast_r, olast_nxt;

  // Memory ports
  logic [IDX_W-1:0]          addr;
  logic                      sum_we;
  logic [SUM_WIDTH-1:0]      sum_wdata;
  logic [SUM_WIDTH-1:0]      sum_rdata;
  logic [SUM_WIDTH-1:0]      sum_base;
  logic                      pre_we;
  logic [BW-1:0]             pre_rdata;

  // Datapath helpers
  logic [BW-1:0]             add_byte;
  logic [SUM_WIDTH-1:0]      add_ext;
  logic                      v_gt1;
  logic                      run_more;
  logic                      out_free;
  logic [IDX_W+OUT_IDX_PAD-1:0] oidx_ext;

  // Memory address follows the phase
  always_comb begin
    case (state_r)
      csh_pkg::S_IDLE, csh_pkg::S_ADD: addr = pos_r;
      csh_pkg::S_DRD,  csh_pkg::S_DWR: addr = dst_r;
      csh_pkg::S_CRD,  csh_pkg::S_CLD: addr = sec_r;
      default:                         addr = pos_r;
    endcase
  end

  // Section sums: never-written or consumed entries read as zero
  assign sum_base  = valid_r[addr] ? sum_rdata : '0;
  assign add_byte  = (state_r == csh_pkg::S_DWR) ? pre_rdata : byte_r;
  assign add_ext   = {{(SUM_WIDTH-BW){add_byte[BW-1]}}, add_byte};
  assign sum_wdata = sum_base + add_ext;
  assign sum_we    = (state_r == csh_pkg::S_ADD) || (state_r == csh_pkg::S_DWR);
  assign pre_we    = (state_r == csh_pkg::S_ADD) && !long_r;

  csh_ram #(
    .WIDTH(SUM_WIDTH),
    .DEPTH(SECTIONS)
  ) u_sum_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(addr),
    .wdata(sum_wdata),
    .raddr(addr),
    .rdata(sum_rdata)
  );

  csh_ram #(
    .WIDTH(BW),
    .DEPTH(SECTIONS)
  ) u_prefix_ram (
    .clk  (clk),
    .we   (pre_we),
    .waddr(pos_r),
    .wdata(byte_r),
    .raddr(src_r),
    .rdata(pre_rdata)
  );

  // Step unit condition
  assign v_gt1    = |v_r[SUM_WIDTH-1:1];
  assign run_more = v_gt1 && (steps_r < limit_r);
  assign out_free = !ovalid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    long_nxt   = long_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    len_nxt    = len_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    j_nxt      = j_r;
    total_nxt  = total_r;
    sec_nxt    = sec_r;
    v_nxt      = v_r;
    hash_nxt   = hash_r;
    steps_nxt  = steps_r;
    ovalid_nxt = ovalid_r;
    ohash_nxt  = ohash_r;
    oidx_nxt   = oidx_r;
    oto_nxt    = oto_r;
    olast_nxt  = olast_r;

    // output register drains on transfer
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      csh_pkg::S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data_byte;
          last_nxt  = in_last_byte;
          state_nxt = csh_pkg::S_ADD;
        end
      end

      csh_pkg::S_ADD: begin
        valid_nxt[pos_r] = 1'b1;
        if (pos_r == LAST_SEC) begin
          pos_nxt  = '0;
          long_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
        if (!last_r) begin
          state_nxt = csh_pkg::S_IDLE;
        end else if (pos_r == LAST_SEC || long_r) begin
          sec_nxt   = '0;
          state_nxt = csh_pkg::S_CRD;
        end else begin
          len_nxt   = pos_r + 1'b1;
          total_nxt = {1'b0, pos_r + 1'b1};
          j_nxt     = {1'b0, pos_r + 1'b1};
          src_nxt   = '0;
          dst_nxt   = pos_r + 1'b1;
          state_nxt = csh_pkg::S_DSIZE;
        end
      end

      // double the length until it covers all sections
      csh_pkg::S_DSIZE: begin
        if (total_r < SEC_J) begin
          total_nxt = {total_r[J_W-2:0], 1'b0};
        end else begin
          state_nxt = csh_pkg::S_DRD;
        end
      end

      csh_pkg::S_DRD: begin
        state_nxt = csh_pkg::S_DWR;
      end

      csh_pkg::S_DWR: begin
        valid_nxt[dst_r] = 1'b1;
        src_nxt = (src_r == len_r - 1'b1) ? '0 : src_r + 1'b1;
        dst_nxt = (dst_r == LAST_SEC) ? '0 : dst_r + 1'b1;
        j_nxt   = j_r + 1'b1;
        if (j_r + 1'b1 == total_r) begin
          sec_nxt   = '0;
          state_nxt = csh_pkg::S_CRD;
        end else begin
          state_nxt = csh_pkg::S_DRD;
        end
      end

      csh_pkg::S_CRD: begin
        state_nxt = csh_pkg::S_CLD;
      end

      // load section sum and clear it for the next message
      csh_pkg::S_CLD: begin
        v_nxt            = sum_base;
        valid_nxt[sec_r] = 1'b0;
        hash_nxt         = '0;
        steps_nxt        = '0;
        state_nxt        = csh_pkg::S_CRUN;
      end

      csh_pkg::S_CRUN: begin
        if (run_more) begin
          if (!v_r[0]) begin
            v_nxt    = {1'b0, v_r[SUM_WIDTH-1:1]};
            hash_nxt = hash_r + 1'b1;
          end else begin
            v_nxt    = {v_r[SUM_WIDTH-2:0], 1'b0} + v_r + 1'b1;
            hash_nxt = hash_r + 2'd2;
          end
          steps_nxt = steps_r + 1'b1;
        end else if (out_free) begin
          ovalid_nxt = 1'b1;
          ohash_nxt  = hash_r;
          oidx_nxt   = sec_r;
          oto_nxt    = v_gt1;
          olast_nxt  = (sec_r == LAST_SEC);
          if (sec_r == LAST_SEC) begin
            pos_nxt   = '0;
            long_nxt  = 1'b0;
            state_nxt = csh_pkg::S_IDLE;
          end else begin
            sec_nxt   = sec_r + 1'b1;
            state_nxt = csh_pkg::S_CRD;
          end
        end
      end

      default: begin
        state_nxt = csh_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= csh_pkg::S_IDLE;
      pos_r    <= '0;
      long_r   <= 1'b0;
      valid_r  <= '0;
      ovalid_r <= 1'b0;
      limit_r  <= '1;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      long_r   <= long_nxt;
      valid_r  <= valid_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_step_limit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    len_r   <= len_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    j_r     <= j_nxt;
    total_r <= total_nxt;
    sec_r   <= sec_nxt;
    v_r     <= v_nxt;
    hash_r  <= hash_nxt;
    steps_r <= steps_nxt;
    ohash_r <= ohash_nxt;
    oidx_r  <= oidx_nxt;
    oto_r   <= oto_nxt;
    olast_r <= olast_nxt;
  end

  // Ports
  assign oidx_ext          = {{OUT_IDX_PAD{1'b0}}, oidx_r};
  assign in_stall          = (state_r != csh_pkg::S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ovalid_r;
  assign out_hash_byte     = ohash_r;
  assign out_section_index = oidx_ext[csh_pkg::OUT_IDX_W-1:0];
  assign out_timed_out     = oto_r;
  assign out_last_result   = olast_r;

endmodule

// File: design/csh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module csh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the Collatz section hash core.
`timescale 1ns / 1ps

module tb;

  localparam int NSEC        = 32;
  localparam int ITEM_TARGET = 260;
  localparam int CYCLE_CAP   = 40_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 70;

  typedef struct packed {
    logic [csh_pkg::BYTE_W-1:0]    hash;
    logic [csh_pkg::OUT_IDX_W-1:0] idx;
    logic                          to;
    logic                          last;
  } hash_res_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_MSG} row_kind_t;

  // One table row: a limit write, or a run of identical bytes
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic [7:0]  count;
    logic        ends;
    logic        typed;
    logic [7:0]  t_hash;
    logic        t_to;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [csh_pkg::BYTE_W-1:0]       in_data_byte;
  logic                             in_last_byte;
  logic                             out_valid;
  logic                             out_stall;
  logic [csh_pkg::BYTE_W-1:0]       out_hash_byte;
  logic [csh_pkg::OUT_IDX_W-1:0]    out_section_index;
  logic                             out_timed_out;
  logic                             out_last_result;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [csh_pkg::LIMIT_W-1:0]      cfg_step_limit;

  collatz_section_hash_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hash_byte     (out_hash_byte),
    .out_section_index (out_section_index),
    .out_timed_out     (out_timed_out),
    .out_last_result   (out_last_result),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_step_limit    (cfg_step_limit)
  );

  // Predictor state
  logic [63:0] sum_acc [NSEC];
  logic [7:0]  prefix_mem [NSEC];
  int unsigned fill_pos;
  bit          seen_full;
  logic [31:0] step_lim_model;
  hash_res_t   hash_due [$];

  int          mismatches   = 0;
  int          results_seen = 0;
  int          items_sent;
  int          cycle_count  = 0;
  bit          burst_mode;
  int          hold_left    = 0;
  bit          held         = 1'b0;
  int          stall_left   = 0;
  int          mode_left    = 0;
  bit          calm         = 1'b0;

  stim_row_t   dir_rows [17];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] widen(logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  // Collatz walk of one section sum, bounded by the step limit
  function automatic void walk_collatz(logic [63:0] start, output logic [7:0] hb,
                                       output logic flag);
    logic [63:0] v;
    logic [31:0] steps;
    logic [31:0] cnt;
    v     = start;
    steps = '0;
    cnt   = '0;
    while (v > 64'd1 && steps < step_lim_model) begin
      if (!v[0]) begin
        v   = v >> 1;
        cnt = cnt + 1;
      end else begin
        v   = v * 3 + 1;
        cnt = cnt + 2;
      end
      steps = steps + 1;
    end
    hb   = cnt[7:0];
    flag = (v > 64'd1);
  endfunction

  // Fold one accepted byte into the section sums; on the last byte, pad a
  // short message, hash every section and queue the results when asked to
  function automatic void absorb_byte(logic [7:0] b, logic is_last, bit record);
    int unsigned pos;
    int unsigned len;
    int unsigned total;
    int unsigned j;
    logic [7:0]  hb;
    logic        flag;
    hash_res_t   r;
    pos = fill_pos;
    sum_acc[pos] = sum_acc[pos] + widen(b);
    if (!seen_full) prefix_mem[pos] = b;
    pos++;
    if (pos >= NSEC) begin
      pos       = 0;
      seen_full = 1'b1;
    end
    fill_pos = pos;
    if (!is_last) return;
    // short message: replay the prefix until the doubled length is reached
    if (!seen_full) begin
      len   = pos;
      total = len;
      while (total < NSEC) total = total * 2;
      for (j = len; j < total; j++)
        sum_acc[j % NSEC] = sum_acc[j % NSEC] + widen(prefix_mem[j % len]);
    end
    for (j = 0; j < NSEC; j++) begin
      walk_collatz(sum_acc[j], hb, flag);
      if (record) begin
        r.hash = hb;
        r.idx  = j[4:0];
        r.to   = flag;
        r.last = (j == NSEC - 1);
        hash_due.push_back(r);
      end
      sum_acc[j] = '0;
    end
    fill_pos  = 0;
    seen_full = 1'b0;
  endfunction

  function automatic stim_row_t mk_row(row_kind_t kind, logic [31:0] value,
                                       logic [7:0] count, logic ends, logic typed,
                                       logic [7:0] t_hash, logic t_to);
    stim_row_t row;
    row.kind   = kind;
    row.value  = value;
    row.count  = count;
    row.ends   = ends;
    row.typed  = typed;
    row.t_hash = t_hash;
    row.t_to   = t_to;
    return row;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // One byte transfer, after a random gap unless the message is a burst
  task automatic send_byte(logic [7:0] b, logic l, bit record);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(b, l, record);
    items_sent++;
  endtask

  // Sender stops until every queued hash byte has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] lim);
    cfg_valid      <= 1'b1;
    cfg_step_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    step_lim_model = lim;
  endtask

  // Result side: check each transfer, then decide the next stall
  always @(posedge clk) begin : result_sink
    hash_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (hash_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, actual section %0d hash %0h", $time,
                 out_section_index, out_hash_byte);
      end else begin
        want = hash_due.pop_front();
        check_field("hash_byte", 32'(want.hash), 32'(out_hash_byte));
        check_field("section_index", 32'(want.idx), 32'(out_section_index));
        check_field("timed_out", 32'(want.to), 32'(out_timed_out));
        check_field("last_result", 32'(want.last), 32'(out_last_result));
      end
    end
    // one long hold-off so the core backs up into its input
    if (!held && results_seen >= HOLD_AFTER) begin
      held      = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          i;
    int          k;
    int          r;
    int          len;
    int          n_msgs;
    logic [31:0] lim;
    bit          safe;
    logic [7:0]  b;
    logic        lb;
    hash_res_t   fixed;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_last_byte   <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_step_limit <= '0;
    for (i = 0; i < NSEC; i++) begin
      sum_acc[i]    = '0;
      prefix_mem[i] = '0;
    end
    fill_pos       = 0;
    seen_full      = 1'b0;
    step_lim_model = 32'hFFFF_FFFF;
    items_sent     = 0;
    burst_mode     = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and one sums, a full 32-byte message, doubling past 32,
    // limit of one with the byte extremes, negative sums, exact doubling
    dir_rows[0]  = mk_row(ROW_CFG, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[1]  = mk_row(ROW_MSG, 32'h00, 8'd1, 1'b1, 1'b1, 8'd0, 1'b0);
    dir_rows[2]  = mk_row(ROW_MSG, 32'h01, 8'd1, 1'b1, 1'b1, 8'd0, 1'b0);
    dir_rows[3]  = mk_row(ROW_MSG, 32'h7F, 8'd1, 1'b1, 1'b0, 8'd0, 1'b0);
    dir_rows[4]  = mk_row(ROW_MSG, 32'h05, 8'd31, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[5]  = mk_row(ROW_MSG, 32'h06, 8'd1, 1'b1, 1'b0, 8'd0, 1'b0);
    dir_rows[6]  = mk_row(ROW_MSG, 32'h2A, 8'd3, 1'b1, 1'b0, 8'd0, 1'b0);
    dir_rows[7]  = mk_row(ROW_CFG, 32'h1, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[8]  = mk_row(ROW_MSG, 32'h02, 8'd1, 1'b1, 1'b1, 8'd1, 1'b0);
    dir_rows[9]  = mk_row(ROW_MSG, 32'h03, 8'd1, 1'b1, 1'b1, 8'd2, 1'b1);
    dir_rows[10] = mk_row(ROW_MSG, 32'h80, 8'd1, 1'b1, 1'b1, 8'd1, 1'b1);
    dir_rows[11] = mk_row(ROW_MSG, 32'hFF, 8'd1, 1'b1, 1'b1, 8'd2, 1'b1);
    dir_rows[12] = mk_row(ROW_CFG, 32'h200, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[13] = mk_row(ROW_MSG, 32'hFF, 8'd2, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[14] = mk_row(ROW_MSG, 32'h80, 8'd1, 1'b1, 1'b0, 8'd0, 1'b0);
    dir_rows[15] = mk_row(ROW_CFG, 32'h7FFF_FFFF, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_rows[16] = mk_row(ROW_MSG, 32'h40, 8'd4, 1'b1, 1'b0, 8'd0, 1'b0);

    for (i = 0; i < 17; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_limit(dir_rows[i].value);
      end else begin
        burst_mode = ($urandom_range(0, 1) == 0);
        for (k = 0; k < dir_rows[i].count; k++) begin
          lb = dir_rows[i].ends && (k == dir_rows[i].count - 1);
          send_byte(dir_rows[i].value[7:0], lb, !(dir_rows[i].typed && lb));
          // uniform hash bytes that can be read straight off the inputs
          if (dir_rows[i].typed && lb) begin
            for (r = 0; r < NSEC; r++) begin
              fixed.hash = dir_rows[i].t_hash;
              fixed.idx  = r[4:0];
              fixed.to   = dir_rows[i].t_to;
              fixed.last = (r == NSEC - 1);
              hash_due.push_back(fixed);
            end
          end
        end
      end
    end

    // Random phases: new limit, then a few messages of mixed length. Large
    // limits only see non-negative bytes so every walk is known to finish.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 5);
      case (r)
        0:       lim = 32'd1;
        1:       lim = $urandom_range(2, 40);
        2:       lim = $urandom_range(41, 600);
        3:       lim = 32'hFFFF_FFFF;
        4:       lim = $urandom() | 32'h8000_0000;
        default: lim = $urandom_range(4096, 32'h7FFF_FFFF);
      endcase
      safe = (lim >= 32'd4096);
      drain_results();
      write_limit(lim);
      n_msgs = $urandom_range(2, 4);
      repeat (n_msgs) begin
        if (items_sent >= ITEM_TARGET) break;
        r = $urandom_range(0, 19);
        if (r < 11) len = $urandom_range(1, 31);
        else if (r < 14) len = NSEC;
        else len = $urandom_range(33, 90);
        burst_mode = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 9);
          if (safe) begin
            b = (r == 0) ? 8'h7F : 8'($urandom_range(0, 127));
          end else begin
            case (r)
              0:       b = 8'h80;
              1:       b = 8'hFF;
              2:       b = 8'h7F;
              default: b = 8'($urandom_range(0, 255));
            endcase
          end
          send_byte(b, k == len - 1, 1'b1);
        end
      end
    end

    in_valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
